[hdl/two_button_chord_detector_macros.svh]
// assertion macros for the chord detector
`ifndef TWO_BUTTON_CHORD_DETECTOR_MACROS_SVH
`define TWO_BUTTON_CHORD_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define TBCD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("tbcd check failed");
// checked at every edge, reset included
`define TBCD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("tbcd check failed");
`else
`define TBCD_ASSERT(lbl, prop)
`define TBCD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hdl/tbcd_pkg.sv]
`timescale 1ns / 1ps

package tbcd_pkg;

	localparam int AGE_BITS = 10;
	localparam int WIN_W    = 10;
	localparam int CMP_W    = (AGE_BITS > WIN_W) ? AGE_BITS : WIN_W;

	localparam logic [AGE_BITS-1:0] AGE_MAX    = {AGE_BITS{1'b1}};
	localparam logic [WIN_W-1:0]    WIN_RESET  = WIN_W'(80);

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]                held;
		logic [1:0]                forwarded;
		logic [1:0]                acted;
		logic [1:0]                pending;
		logic [1:0][AGE_BITS-1:0]  age;
		logic                      chord_used;
		logic                      mouse_mode;
	} state_t;

	typedef struct packed {
		logic consumed;
		logic action_valid;
		logic action_button;
		logic action_press;
		logic mode_active;
		logic mode_toggled;
		logic last;
	} result_t;

	typedef struct packed {
		state_t     nxt;
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} step_t;

endpackage

[hdl/tbcd_evt_if.sv]
`timescale 1ns / 1ps

interface tbcd_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       button;

	modport source (output valid, output op, output button, input ready);
	modport sink (input valid, input op, input button, output ready);
endinterface

[hdl/tbcd_res_if.sv]
`timescale 1ns / 1ps

interface tbcd_res_if;
	logic valid;
	logic ready;
	logic consumed;
	logic action_valid;
	logic action_button;
	logic action_press;
	logic mode_active;
	logic mode_toggled;
	logic last;

	modport source (
		output valid, output consumed, output action_valid, output action_button,
		output action_press, output mode_active, output mode_toggled, output last,
		input ready
	);
	modport sink (
		input valid, input consumed, input action_valid, input action_button,
		input action_press, input mode_active, input mode_toggled, input last,
		output ready
	);
endinterface

[hdl/tbcd_cfg_if.sv]
`timescale 1ns / 1ps

interface tbcd_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/tbcd_step.sv]
`timescale 1ns / 1ps

module tbcd_step (
	input  tbcd_pkg::state_t           cur,
	input  logic [1:0]                 op,
	input  logic                       button,
	input  logic [tbcd_pkg::WIN_W-1:0] window,
	output tbcd_pkg::step_t            step
);
	import tbcd_pkg::*;

	logic                b;
	logic                o;
	logic [CMP_W-1:0]    win_ext;
	logic [CMP_W-1:0]    age_o_ext;
	logic [1:0]          fire_act;
	state_t              nxt;
	result_t             r0;
	result_t             r1;
	logic [1:0]          cnt;

	assign b         = button;
	assign o         = ~button;
	assign win_ext   = CMP_W'(window);
	assign age_o_ext = CMP_W'(cur.age[o]);

	always_comb begin
		nxt      = cur;
		r0       = '0;
		r1       = '0;
		cnt      = 2'd0;
		fire_act = 2'b00;
		case (op)
			OP_PRESS: begin
				nxt.held[b] = 1'b1;
				nxt.age[b]  = '0;
				cnt         = 2'd1;
				if (cur.held[o] && !cur.chord_used && age_o_ext <= win_ext) begin
					nxt.chord_used = 1'b1;
					nxt.pending[o] = 1'b0;
					nxt.mouse_mode = ~cur.mouse_mode;
					r0.consumed     = 1'b1;
					r0.mode_toggled = 1'b1;
				end else if (cur.mouse_mode) begin
					nxt.pending[b] = 1'b1;
					r0.consumed    = 1'b1;
				end else begin
					nxt.forwarded[b] = 1'b1;
				end
			end
			OP_RELEASE: begin
				nxt.held[b] = 1'b0;
				cnt         = 2'd1;
				if (!cur.held[o]) begin
					nxt.chord_used = 1'b0;
				end
				if (cur.forwarded[b]) begin
					nxt.forwarded[b] = 1'b0;
				end else if (cur.acted[b]) begin
					nxt.acted[b]     = 1'b0;
					r0.consumed      = 1'b1;
					r0.action_valid  = 1'b1;
					r0.action_button = b;
				end else if (cur.pending[b]) begin
					nxt.pending[b]   = 1'b0;
					r0.consumed      = 1'b1;
					r0.action_valid  = 1'b1;
					r0.action_button = b;
					r0.action_press  = 1'b1;
					r1.consumed      = 1'b1;
					r1.action_valid  = 1'b1;
					r1.action_button = b;
					cnt              = 2'd2;
				end else begin
					r0.consumed = 1'b1;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < 2; i++) begin
					if (cur.age[i] != AGE_MAX) begin
						nxt.age[i] = cur.age[i] + 1'b1;
					end
				end
				fire_act[0] = cur.mouse_mode && cur.pending[0] &&
					CMP_W'(nxt.age[0]) >= win_ext;
				fire_act[1] = cur.mouse_mode && cur.pending[1] &&
					CMP_W'(nxt.age[1]) >= win_ext;
				for (int i = 0; i < 2; i++) begin
					if (fire_act[i]) begin
						nxt.pending[i] = 1'b0;
						nxt.acted[i]   = 1'b1;
					end
				end
				r0.consumed = 1'b1;
				r1.consumed = 1'b1;
				if (fire_act[0]) begin
					r0.action_valid  = 1'b1;
					r0.action_press  = 1'b1;
					if (fire_act[1]) begin
						r1.action_valid  = 1'b1;
						r1.action_button = 1'b1;
						r1.action_press  = 1'b1;
					end
				end else if (fire_act[1]) begin
					r0.action_valid  = 1'b1;
					r0.action_button = 1'b1;
					r0.action_press  = 1'b1;
				end
				cnt = (fire_act == 2'b11) ? 2'd2 : 2'd1;
			end
			default: begin
				cnt = 2'd0;
			end
		endcase
		r0.mode_active = nxt.mouse_mode;
		r1.mode_active = nxt.mouse_mode;
		r0.last        = (cnt == 2'd1);
		r1.last        = 1'b1;
	end

	assign step.nxt = nxt;
	assign step.cnt = cnt;
	assign step.r0  = r0;
	assign step.r1  = r1;

endmodule

[hdl/two_button_chord_detector.sv]
// Two-button chord qualifier. Each transfer on evt is a press, a release or a
// one-millisecond tick; each gives one or two results on res (none for op code
// three), the final one marked by last. Pressing both buttons within
// chord_window_ms toggles mouse mode once per chord; in mouse mode a single
// press is held back until its age reaches the window or it is released.
// An event is taken into an input register and resolved there against the
// state once the queue has room. One event is accepted per cycle while the
// queue has room; results leave one per cycle while res.ready is high, from
// a four-entry queue. The input stalls while the queue, counting an entry
// being read out, lacks two free entries. The user must write chord_window_ms
// through cfg only while no event is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "two_button_chord_detector_macros.svh"

module two_button_chord_detector (
	input  logic           clk,
	input  logic           arst_n,
	tbcd_evt_if.sink       evt,
	tbcd_res_if.source     res,
	tbcd_cfg_if.sink       cfg
);
	import tbcd_pkg::*;

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic              button_s1;
	state_t            state_q;
	logic [WIN_W-1:0]  window_q;
	result_t           fifo_q [4];
	logic [1:0]        wr_ptr_q;
	logic [1:0]        rd_ptr_q;
	logic [2:0]        count_q;
	step_t             step;
	logic              room;
	logic              fire;
	logic              pop;
	logic [1:0]        push;
	result_t           head;

	tbcd_step u_step (
		.cur    (state_q),
		.op     (op_s1),
		.button (button_s1),
		.window (window_q),
		.step   (step)
	);

	assign pop       = res.valid && res.ready;
	assign room      = (count_q <= 3'd2) || (count_q == 3'd3 && pop);
	assign fire      = valid_s1 && room;
	assign push      = fire ? step.cnt : 2'd0;
	assign evt.ready = !valid_s1 || fire;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1     <= evt.op;
			button_s1 <= evt.button;
		end
	end

	// chord state and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			window_q <= WIN_RESET;
		end else begin
			if (fire) begin
				state_q <= step.nxt;
			end
			if (cfg.valid && cfg.ready) begin
				window_q <= cfg.data;
			end
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_q[wr_ptr_q] <= step.r0;
		end
		if (push == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= step.r1;
		end
	end

	assign head              = fifo_q[rd_ptr_q];
	assign res.valid         = (count_q != 3'd0);
	assign res.consumed      = head.consumed;
	assign res.action_valid  = head.action_valid;
	assign res.action_button = head.action_button;
	assign res.action_press  = head.action_press;
	assign res.mode_active   = head.mode_active;
	assign res.mode_toggled  = head.mode_toggled;
	assign res.last          = head.last;

	`TBCD_ASSERT_ALWAYS(a_queue_bound, !arst_n || count_q <= 3'd4)
	`TBCD_ASSERT(a_group_follows, (pop && !res.last) |=> res.valid)
	`TBCD_ASSERT(a_toggle_swallowed, res.valid && res.mode_toggled |-> res.consumed && !res.action_valid)
	`TBCD_ASSERT(a_stall_holds, (valid_s1 && !fire) |-> !evt.ready)

endmodule
